@@ hw/rtl/lcdseq_pkg.sv @@
`default_nettype none

package lcdseq_pkg;

   // Characters on one display line
   localparam int LINE_CHARS = 16;
   localparam int POS_W      = $clog2(LINE_CHARS + 1);
   localparam int IDX_W      = $clog2(LINE_CHARS);

   // Depth of the queue between sequencer and expander
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_POLL  = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_PRINT = 2'd2,
      CMD_INIT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_DEVICE_ADDRESS = 2'd0,
      CSR_POWER_UP_WAIT  = 2'd1,
      CSR_CLEAR_WAIT     = 2'd2,
      CSR_CHAR_GAP       = 2'd3
   } csr_index_type;

   localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd39;
   localparam logic [7:0] POWER_UP_WAIT_RST  = 8'd50;
   localparam logic [7:0] CLEAR_WAIT_RST     = 8'd2;
   localparam logic [7:0] CHAR_GAP_RST       = 8'd1;

   // Controller command codes
   localparam logic [7:0] LCD_WAKE         = 8'h30;
   localparam logic [7:0] LCD_FOUR_BIT     = 8'h20;
   localparam logic [7:0] LCD_FUNCTION_SET = 8'h28;
   localparam logic [7:0] LCD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] LCD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] LCD_CLEAR        = 8'h01;
   localparam logic [7:0] LCD_SET_DDRAM    = 8'h80;
   localparam logic [7:0] SPACE_CHAR       = 8'h20;
   localparam logic [7:0] SETTLE_MS        = 8'd5;

   // Expander bit positions
   localparam logic [7:0] NIBBLE_MASK = 8'hF0;
   localparam logic [7:0] BIT_BL      = 8'h08;
   localparam logic [7:0] BIT_EN      = 8'h04;
   localparam logic [7:0] BIT_RS      = 8'h01;

   // One controller write waiting for expansion
   typedef struct packed {
      logic [7:0] code;
      logic       is_data;
      logic [6:0] dev_address;
      logic       busy;
      logic       init_done;
   } lcdseq_entry_type;

endpackage

`default_nettype wire

@@ hw/rtl/lcdseq_front.sv @@
`default_nettype none

module lcdseq_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_accept,
   input  wire logic [1:0]                req_cmd,
   input  wire logic                      req_bus_idle,
   input  wire logic                      req_ms_tick,
   input  wire logic [3:0]                req_char_index,
   input  wire logic [7:0]                req_char_value,
   input  wire logic [4:0]                req_text_len,
   input  wire logic                      csr_write,
   input  wire logic [1:0]                csr_index,
   input  wire logic [7:0]                csr_wdata,
   output logic                           entry_push,
   output lcdseq_pkg::lcdseq_entry_type   entry
);
   import lcdseq_pkg::*;

   typedef enum logic [3:0] {
      IP_IDLE       = 4'd0,
      IP_POWER      = 4'd1,
      IP_WAKE_A     = 4'd2,
      IP_SETTLE_A   = 4'd3,
      IP_WAKE_B     = 4'd4,
      IP_SETTLE_B   = 4'd5,
      IP_WAKE_C     = 4'd6,
      IP_SETTLE_C   = 4'd7,
      IP_FOUR_BIT   = 4'd8,
      IP_SETTLE_D   = 4'd9,
      IP_FUNCTION   = 4'd10,
      IP_DISPLAY    = 4'd11,
      IP_ENTRY      = 4'd12,
      IP_CLEAR      = 4'd13,
      IP_CLEAR_WAIT = 4'd14,
      IP_DONE       = 4'd15
   } init_phase_type;

   typedef enum logic [2:0] {
      PP_IDLE       = 3'd0,
      PP_CLEAR      = 3'd1,
      PP_CLEAR_WAIT = 3'd2,
      PP_ADDR       = 3'd3,
      PP_WRITE      = 3'd4,
      PP_DONE       = 3'd5
   } print_phase_type;

   logic [6:0]       device_address_ff;
   logic [7:0]       power_up_wait_ff;
   logic [7:0]       clear_wait_ff;
   logic [7:0]       char_gap_ff;

   init_phase_type   init_phase_ff, init_phase_in;
   print_phase_type  print_phase_ff, print_phase_in;
   logic [7:0]       init_countdown_ff, init_countdown_in;
   logic [7:0]       print_countdown_ff, print_countdown_in;
   logic [POS_W-1:0] text_length_ff, text_length_in;
   logic [POS_W-1:0] char_position_ff, char_position_in;
   logic [7:0]       line_store_ff [LINE_CHARS];

   logic             load_hit;
   logic [IDX_W-1:0] wr_idx;
   logic [7:0]       stored_char;
   logic             send;
   logic [7:0]       send_code;
   logic             send_data;

   assign load_hit = (cmd_type'(req_cmd) == CMD_LOAD)
                     && (32'(req_char_index) < 32'(LINE_CHARS));
   assign wr_idx   = IDX_W'(req_char_index);

   always_comb begin
      init_countdown_in  = init_countdown_ff;
      print_countdown_in = print_countdown_ff;
      init_phase_in      = init_phase_ff;
      print_phase_in     = print_phase_ff;
      text_length_in     = text_length_ff;
      char_position_in   = char_position_ff;
      send               = 1'b0;
      send_code          = LCD_CLEAR;
      send_data          = 1'b0;
      stored_char        = SPACE_CHAR;

      // count down the millisecond timers first
      if (req_ms_tick) begin
         if (init_countdown_in != 8'd0) init_countdown_in = init_countdown_in - 8'd1;
         if (print_countdown_in != 8'd0) print_countdown_in = print_countdown_in - 8'd1;
      end

      case (cmd_type'(req_cmd))
         CMD_PRINT: begin
            text_length_in   = (32'(req_text_len) > 32'(LINE_CHARS)) ?
                               POS_W'(LINE_CHARS) : POS_W'(req_text_len);
            char_position_in = '0;
            print_phase_in   = PP_CLEAR;
         end
         CMD_INIT: begin
            init_phase_in     = IP_POWER;
            init_countdown_in = power_up_wait_ff;
         end
         default: ;
      endcase

      case (init_phase_in)
         IP_POWER:      if (init_countdown_in == 8'd0) init_phase_in = IP_WAKE_A;
         IP_SETTLE_A:   if (init_countdown_in == 8'd0) init_phase_in = IP_WAKE_B;
         IP_SETTLE_B:   if (init_countdown_in == 8'd0) init_phase_in = IP_WAKE_C;
         IP_SETTLE_C:   if (init_countdown_in == 8'd0) init_phase_in = IP_FOUR_BIT;
         IP_SETTLE_D:   if (init_countdown_in == 8'd0) init_phase_in = IP_FUNCTION;
         IP_CLEAR_WAIT: if (init_countdown_in == 8'd0) init_phase_in = IP_DONE;
         IP_WAKE_A: if (req_bus_idle) begin
            send = 1'b1; send_code = LCD_WAKE;
            init_countdown_in = SETTLE_MS; init_phase_in = IP_SETTLE_A;
         end
         IP_WAKE_B: if (req_bus_idle) begin
            send = 1'b1; send_code = LCD_WAKE;
            init_countdown_in = char_gap_ff; init_phase_in = IP_SETTLE_B;
         end
         IP_WAKE_C: if (req_bus_idle) begin
            send = 1'b1; send_code = LCD_WAKE;
            init_countdown_in = char_gap_ff; init_phase_in = IP_SETTLE_C;
         end
         IP_FOUR_BIT: if (req_bus_idle) begin
            send = 1'b1; send_code = LCD_FOUR_BIT;
            init_countdown_in = char_gap_ff; init_phase_in = IP_SETTLE_D;
         end
         IP_FUNCTION: if (req_bus_idle) begin
            send = 1'b1; send_code = LCD_FUNCTION_SET; init_phase_in = IP_DISPLAY;
         end
         IP_DISPLAY: if (req_bus_idle) begin
            send = 1'b1; send_code = LCD_DISPLAY_ON; init_phase_in = IP_ENTRY;
         end
         IP_ENTRY: if (req_bus_idle) begin
            send = 1'b1; send_code = LCD_ENTRY_MODE; init_phase_in = IP_CLEAR;
         end
         IP_CLEAR: if (req_bus_idle) begin
            send = 1'b1; send_code = LCD_CLEAR;
            init_countdown_in = clear_wait_ff; init_phase_in = IP_CLEAR_WAIT;
         end
         default: ;
      endcase

      // print advances only on a quiet init step with init finished
      if (!send && init_phase_in == IP_DONE) begin
         case (print_phase_in)
            PP_IDLE: ;
            PP_CLEAR: if (req_bus_idle) begin
               send = 1'b1; send_code = LCD_CLEAR;
               print_countdown_in = clear_wait_ff; print_phase_in = PP_CLEAR_WAIT;
            end
            PP_CLEAR_WAIT: if (print_countdown_in == 8'd0) print_phase_in = PP_ADDR;
            PP_ADDR: if (req_bus_idle) begin
               send = 1'b1; send_code = LCD_SET_DDRAM;
               char_position_in = '0; print_phase_in = PP_WRITE;
            end
            PP_WRITE: if (req_bus_idle) begin
               if (32'(char_position_in) < 32'(LINE_CHARS)) begin
                  if (print_countdown_in == 8'd0) begin
                     // forward a load to the same position in this item
                     if (load_hit && wr_idx == char_position_in[IDX_W-1:0])
                        stored_char = req_char_value;
                     else
                        stored_char = line_store_ff[char_position_in[IDX_W-1:0]];
                     send      = 1'b1;
                     send_data = 1'b1;
                     send_code = (char_position_in < text_length_in) ?
                                 stored_char : SPACE_CHAR;
                     char_position_in   = POS_W'(char_position_in + 1'b1);
                     print_countdown_in = char_gap_ff;
                  end
               end else begin
                  print_phase_in = PP_DONE;
               end
            end
            default: print_phase_in = PP_IDLE;
         endcase
      end
   end

   assign entry_push        = in_accept && send;
   assign entry.code        = send_code;
   assign entry.is_data     = send_data;
   assign entry.dev_address = device_address_ff;
   assign entry.busy        = (print_phase_in != PP_IDLE);
   assign entry.init_done   = (init_phase_in == IP_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff  <= DEVICE_ADDRESS_RST;
         power_up_wait_ff   <= POWER_UP_WAIT_RST;
         clear_wait_ff      <= CLEAR_WAIT_RST;
         char_gap_ff        <= CHAR_GAP_RST;
         init_phase_ff      <= IP_IDLE;
         print_phase_ff     <= PP_IDLE;
         init_countdown_ff  <= 8'd0;
         print_countdown_ff <= 8'd0;
         text_length_ff     <= '0;
         char_position_ff   <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_DEVICE_ADDRESS: device_address_ff <= csr_wdata[6:0];
               CSR_POWER_UP_WAIT:  power_up_wait_ff  <= csr_wdata;
               CSR_CLEAR_WAIT:     clear_wait_ff     <= csr_wdata;
               CSR_CHAR_GAP:       char_gap_ff       <= csr_wdata;
               default: ;
            endcase
         end
         if (in_accept) begin
            init_phase_ff      <= init_phase_in;
            print_phase_ff     <= print_phase_in;
            init_countdown_ff  <= init_countdown_in;
            print_countdown_ff <= print_countdown_in;
            text_length_ff     <= text_length_in;
            char_position_ff   <= char_position_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept && load_hit) line_store_ff[wr_idx] <= req_char_value;
   end

   a_send_needs_bus: assert property (@(posedge clock) disable iff (reset)
      entry_push |-> req_bus_idle)
      else $error("write issued while the bus writer is busy");

   a_char_after_init: assert property (@(posedge clock) disable iff (reset)
      (entry_push && entry.is_data) |-> entry.init_done)
      else $error("character sent before init completed");

   a_position_in_line: assert property (@(posedge clock) disable iff (reset)
      32'(char_position_ff) <= 32'(LINE_CHARS))
      else $error("character position ran past the line");

endmodule

`default_nettype wire

@@ hw/rtl/lcdseq_fifo.sv @@
`default_nettype none

module lcdseq_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      wr_en,
   input  wire lcdseq_pkg::lcdseq_entry_type wr_data,
   input  wire logic                      rd_en,
   output lcdseq_pkg::lcdseq_entry_type   rd_data,
   output logic                           is_full,
   output logic                           is_empty
);
   import lcdseq_pkg::*;

   lcdseq_entry_type  slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign is_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);
   assign rd_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en)
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
      if (rd_en)
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
      if (wr_en && !rd_en)
         count_in = QCNT_W'(count_ff + 1'b1);
      else if (rd_en && !wr_en)
         count_in = QCNT_W'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) slot_ff[wr_ptr_ff] <= wr_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!is_full || rd_en))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !is_empty)
      else $error("queue read while empty");

endmodule

`default_nettype wire

@@ hw/rtl/lcdseq_back.sv @@
`default_nettype none

module lcdseq_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lcdseq_pkg::lcdseq_entry_type q_data,
   input  wire logic                      q_empty,
   output logic                           q_pop,
   input  wire logic                      pop,
   output logic                           empty,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_byte_valid,
   output logic                           rsp_last_byte,
   output logic [6:0]                     rsp_dev_address,
   output logic                           rsp_busy_res,
   output logic                           rsp_init_done
);
   import lcdseq_pkg::*;

   lcdseq_entry_type cur_ff;
   logic             valid_ff, valid_in;
   logic [1:0]       beat_ff, beat_in;
   logic             beat_done;
   logic [7:0]       nibble;

   assign beat_done = valid_ff && pop && (beat_ff == 2'd3);
   assign q_pop     = !q_empty && (!valid_ff || beat_done);

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (q_pop) begin
         valid_in = 1'b1;
         beat_in  = 2'd0;
      end else if (beat_done) begin
         valid_in = 1'b0;
      end else if (valid_ff && pop) begin
         beat_in = beat_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_data;
   end

   // high nibble on beats 0 and 1, low nibble on 2 and 3; strobe on even beats
   assign nibble = beat_ff[1] ? {cur_ff.code[3:0], 4'h0} : (cur_ff.code & NIBBLE_MASK);

   assign empty           = !valid_ff;
   assign rsp_out_byte    = nibble | BIT_BL | (beat_ff[0] ? 8'h00 : BIT_EN)
                            | (cur_ff.is_data ? BIT_RS : 8'h00);
   assign rsp_byte_valid  = 1'b1;
   assign rsp_last_byte   = (beat_ff == 2'd3);
   assign rsp_dev_address = cur_ff.dev_address;
   assign rsp_busy_res    = cur_ff.busy;
   assign rsp_init_done   = cur_ff.init_done;

   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (valid_ff && beat_ff == 2'd0))
      else $error("new write did not start at its first byte");

   a_drain_to_empty: assert property (@(posedge clock) disable iff (reset)
      (beat_done && q_empty) |=> !valid_ff)
      else $error("result held after its last byte with nothing queued");

endmodule

`default_nettype wire

@@ hw/rtl/char_lcd_i2c_backpack_sequencer_top.sv @@
`default_nettype none

// Character LCD sequencer behind an I2C port expander, 4-bit bus mode.
//
// Request side (push/full): each item is one poll carrying a command
// (poll, load character, start print, start init), the writer's bus_idle
// flag and a millisecond tick. An item is taken when push is high and full
// is low; the sequencer state updates in that same cycle.
// Response side (empty/pop): an item that issues a controller write yields
// four expander bytes, strobe high then low for each nibble, the fourth
// marked last_byte. A byte is on the rsp_ ports while empty is low and
// leaves on pop.
// A write's first byte shows after the queue slot and the expander's
// current-write register. The expander emits one byte per cycle while
// pop is high; items without a write pass at one per cycle while full
// is low. A two-entry queue sits between sequencer and expander; full
// rises only when that queue has no room, so a stalled receiver backs
// up into full after two pending writes plus the one being emitted.
// Configuration (valid/ready, csr_index, csr_wdata) is always ready; the
// user must write it only while no items are in flight (not enforced).
// Reset: sequencers idle, timers zero, registers at their defaults, queue
// and expander empty. The line buffer is not cleared.
module char_lcd_i2c_backpack_sequencer_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   output logic            full,
   input  wire logic [1:0] req_cmd,
   input  wire logic       req_bus_idle,
   input  wire logic       req_ms_tick,
   input  wire logic [3:0] req_char_index,
   input  wire logic [7:0] req_char_value,
   input  wire logic [4:0] req_text_len,
   output logic            empty,
   input  wire logic       pop,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_byte_valid,
   output logic            rsp_last_byte,
   output logic [6:0]      rsp_dev_address,
   output logic            rsp_busy_res,
   output logic            rsp_init_done,
   input  wire logic       valid,
   output logic            ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_wdata
);
   import lcdseq_pkg::*;

   logic             in_accept;
   logic             entry_push;
   lcdseq_entry_type entry;
   lcdseq_entry_type q_data;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;

   // hold requests while the queue has no room for a possible write
   assign full      = q_full;
   assign in_accept = push && !q_full;
   assign ready     = 1'b1;

   lcdseq_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_accept      (in_accept),
      .req_cmd        (req_cmd),
      .req_bus_idle   (req_bus_idle),
      .req_ms_tick    (req_ms_tick),
      .req_char_index (req_char_index),
      .req_char_value (req_char_value),
      .req_text_len   (req_text_len),
      .csr_write      (valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .entry_push     (entry_push),
      .entry          (entry)
   );

   lcdseq_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (entry_push),
      .wr_data  (entry),
      .rd_en    (q_pop),
      .rd_data  (q_data),
      .is_full  (q_full),
      .is_empty (q_empty)
   );

   // expand each queued write into its four expander bytes
   lcdseq_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_data          (q_data),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_dev_address (rsp_dev_address),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_init_done   (rsp_init_done)
   );

endmodule

`default_nettype wire

@@ test/tb_char_lcd_i2c_backpack_sequencer_top.sv @@
`timescale 1ns / 100ps

module tb_char_lcd_i2c_backpack_sequencer_top;
   import lcdseq_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   // Margin kept after the last predicted byte leaves the expander
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_IDLE      = 13;
   localparam int RANDOM_ITEMS  = 140;
   localparam int REPORT_LIMIT  = 10;

   // Power-up sequence steps, in the order the controller walks them
   typedef enum logic [3:0] {
      IN_IDLE, IN_POWER, IN_WAKE1, IN_WAIT1, IN_WAKE2, IN_WAIT2, IN_WAKE3, IN_WAIT3,
      IN_FOUR_BIT, IN_WAIT4, IN_FUNC_SET, IN_DISP_ON, IN_ENTRY, IN_CLEAR,
      IN_CLEAR_WAIT, IN_DONE
   } init_phase_type;

   typedef enum logic [2:0] {
      PR_IDLE, PR_CLEAR, PR_CLEAR_WAIT, PR_ADDR, PR_WRITE, PR_DONE
   } print_phase_type;

   // One expander byte as it should appear on the response side
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic [6:0] dev_address;
      logic       busy;
      logic       init_done;
   } lcd_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic       full;
   logic [1:0] req_cmd = CMD_POLL;
   logic       req_bus_idle = 1'b0;
   logic       req_ms_tick = 1'b0;
   logic [3:0] req_char_index = '0;
   logic [7:0] req_char_value = '0;
   logic [4:0] req_text_len = '0;
   logic       empty;
   logic       pop = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_last_byte;
   logic [6:0] rsp_dev_address;
   logic       rsp_busy_res;
   logic       rsp_init_done;
   logic       valid = 1'b0;
   logic       ready;
   logic [1:0] csr_index = CSR_DEVICE_ADDRESS;
   logic [7:0] csr_wdata = '0;

   char_lcd_i2c_backpack_sequencer_top dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_cmd         (req_cmd),
      .req_bus_idle    (req_bus_idle),
      .req_ms_tick     (req_ms_tick),
      .req_char_index  (req_char_index),
      .req_char_value  (req_char_value),
      .req_text_len    (req_text_len),
      .empty           (empty),
      .pop             (pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_byte   (rsp_last_byte),
      .rsp_dev_address (rsp_dev_address),
      .rsp_busy_res    (rsp_busy_res),
      .rsp_init_done   (rsp_init_done),
      .valid           (valid),
      .ready           (ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #2 clock = ~clock;

   // Shadow copy of the registers and sequencer state, advanced per accepted item
   logic [6:0]      dev_addr_reg = DEVICE_ADDRESS_RST;
   logic [7:0]      power_wait_reg = POWER_UP_WAIT_RST;
   logic [7:0]      clear_wait_reg = CLEAR_WAIT_RST;
   logic [7:0]      char_gap_reg = CHAR_GAP_RST;
   init_phase_type  init_step = IN_IDLE;
   logic [7:0]      init_timer = '0;
   print_phase_type print_step = PR_IDLE;
   logic [7:0]      print_timer = '0;
   logic [7:0]      line_buf [LINE_CHARS];
   logic [4:0]      text_cnt = '0;
   logic [4:0]      char_pos = '0;

   lcd_byte_type expected_bytes [$];
   int        mismatches = 0;
   int        cycle_count = 0;
   bit        push_quiet = 1'b0;
   bit        pop_quiet = 1'b0;

   // Hang guard: a stuck handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Idle length for the next item; now and then flip into or out of a
   // back-to-back stretch so both busy runs and gaps show up
   function automatic int draw_wait(inout bit quiet);
      if ($urandom_range(0, 24) == 0)
         quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   // Advance the shadow state by one item and queue the expander bytes it causes
   task automatic predict_expander_bytes(input cmd_type c, input logic bus_ok,
                                         input logic tick, input logic [3:0] idx,
                                         input logic [7:0] val, input logic [4:0] len);
      logic         send;
      logic         is_char;
      logic [7:0]   code;
      logic [7:0]   nibble;
      lcd_byte_type b;
      send = 1'b0;
      is_char = 1'b0;
      code = '0;

      // Millisecond tick drains both timers, stopping at zero
      if (tick) begin
         if (init_timer != 0) init_timer = init_timer - 8'd1;
         if (print_timer != 0) print_timer = print_timer - 8'd1;
      end

      case (c)
         CMD_LOAD: begin
            line_buf[idx] = val;
         end
         CMD_PRINT: begin
            text_cnt = (len > LINE_CHARS) ? 5'(LINE_CHARS) : len;
            char_pos = '0;
            print_step = PR_CLEAR;
         end
         CMD_INIT: begin
            init_step = IN_POWER;
            init_timer = power_wait_reg;
         end
         default: ;
      endcase

      // Init sequencer: wait steps move on when their timer has run out,
      // send steps only when the bus writer is free
      case (init_step)
         IN_POWER, IN_WAIT1, IN_WAIT2, IN_WAIT3, IN_WAIT4, IN_CLEAR_WAIT: begin
            if (init_timer == 0)
               init_step = init_phase_type'(init_step + 4'd1);
         end
         IN_WAKE1: begin
            code = LCD_WAKE;
            if (bus_ok) init_timer = SETTLE_MS;
            send = bus_ok;
         end
         IN_WAKE2, IN_WAKE3: begin
            code = LCD_WAKE;
            if (bus_ok) init_timer = char_gap_reg;
            send = bus_ok;
         end
         IN_FOUR_BIT: begin
            code = LCD_FOUR_BIT;
            if (bus_ok) init_timer = char_gap_reg;
            send = bus_ok;
         end
         IN_FUNC_SET: begin
            code = LCD_FUNCTION_SET;
            send = bus_ok;
         end
         IN_DISP_ON: begin
            code = LCD_DISPLAY_ON;
            send = bus_ok;
         end
         IN_ENTRY: begin
            code = LCD_ENTRY_MODE;
            send = bus_ok;
         end
         IN_CLEAR: begin
            code = LCD_CLEAR;
            if (bus_ok) init_timer = clear_wait_reg;
            send = bus_ok;
         end
         default: ;
      endcase
      if (send)
         init_step = init_phase_type'(init_step + 4'd1);

      // Print sequencer only runs once init has finished and stayed quiet
      if (!send && init_step == IN_DONE) begin
         case (print_step)
            PR_CLEAR: begin
               if (bus_ok) begin
                  print_timer = clear_wait_reg;
                  print_step = PR_CLEAR_WAIT;
                  code = LCD_CLEAR;
                  send = 1'b1;
               end
            end
            PR_CLEAR_WAIT: begin
               if (print_timer == 0)
                  print_step = PR_ADDR;
            end
            PR_ADDR: begin
               if (bus_ok) begin
                  char_pos = '0;
                  print_step = PR_WRITE;
                  code = LCD_SET_DDRAM;
                  send = 1'b1;
               end
            end
            PR_WRITE: begin
               if (bus_ok) begin
                  if (char_pos < LINE_CHARS) begin
                     if (print_timer == 0) begin
                        code = (char_pos < text_cnt) ? line_buf[char_pos[3:0]] : SPACE_CHAR;
                        char_pos = char_pos + 5'd1;
                        print_timer = char_gap_reg;
                        is_char = 1'b1;
                        send = 1'b1;
                     end
                  end else begin
                     print_step = PR_DONE;
                  end
               end
            end
            default: print_step = PR_IDLE;
         endcase
      end

      // High nibble strobed then released, low nibble likewise
      if (send) begin
         for (int k = 0; k < 4; k++) begin
            nibble = (k < 2) ? (code & NIBBLE_MASK) : {code[3:0], 4'h0};
            b.out_byte = nibble | BIT_BL | ((k % 2 == 0) ? BIT_EN : 8'h00)
                         | (is_char ? BIT_RS : 8'h00);
            b.last_byte = (k == 3);
            b.dev_address = dev_addr_reg;
            b.busy = (print_step != PR_IDLE);
            b.init_done = (init_step == IN_DONE);
            expected_bytes.push_back(b);
         end
      end
   endtask

   // Offer one item after a random idle spell; hold it until full drops
   task automatic send_item(input cmd_type c, input logic bus_ok, input logic tick,
                            input logic [3:0] idx, input logic [7:0] val,
                            input logic [4:0] len);
      int gap;
      gap = draw_wait(push_quiet);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_cmd <= c;
      req_bus_idle <= bus_ok;
      req_ms_tick <= tick;
      req_char_index <= idx;
      req_char_value <= val;
      req_text_len <= len;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_expander_bytes(c, bus_ok, tick, idx, val, len);
   endtask

   task automatic send_random_item();
      int      pick;
      cmd_type c;
      pick = $urandom_range(0, 99);
      if (pick < 84)
         c = CMD_POLL;
      else if (pick < 96)
         c = CMD_LOAD;
      else if (pick < 99)
         c = CMD_PRINT;
      else
         c = CMD_INIT;
      send_item(c, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 70,
                4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                5'($urandom_range(0, 31)));
   endtask

   // Stop offering items, let every queued byte out, then wait for stragglers
   task automatic drain();
      push <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back, valid held high throughout
   task automatic write_registers(input logic [6:0] addr, input logic [7:0] power_wait,
                                  input logic [7:0] clear_wait, input logic [7:0] char_gap);
      csr_index_type regs [4];
      logic [7:0]    data [4];
      regs[0] = CSR_DEVICE_ADDRESS;
      regs[1] = CSR_POWER_UP_WAIT;
      regs[2] = CSR_CLEAR_WAIT;
      regs[3] = CSR_CHAR_GAP;
      data[0] = {1'b0, addr};
      data[1] = power_wait;
      data[2] = clear_wait;
      data[3] = char_gap;
      valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= regs[i];
         csr_wdata <= data[i];
         @(posedge clock);
         while (!ready) @(posedge clock);
      end
      valid <= 1'b0;
      dev_addr_reg = addr;
      power_wait_reg = power_wait;
      clear_wait_reg = clear_wait;
      char_gap_reg = char_gap;
   endtask

   // One pass: quiesce, reprogram, kick off init with a print queued behind it,
   // then free-running polls with loads and the odd restart mixed in
   task automatic run_episode(input logic [6:0] addr, input logic [7:0] power_wait,
                              input logic [7:0] clear_wait, input logic [7:0] char_gap,
                              input int polls);
      drain();
      write_registers(addr, power_wait, clear_wait, char_gap);
      send_item(CMD_INIT, 1'b1, 1'($urandom_range(0, 1)), '0, '0, '0);
      send_item(CMD_PRINT, 1'b1, 1'($urandom_range(0, 1)), '0, '0,
                5'($urandom_range(0, 31)));
      repeat (polls) send_random_item();
   endtask

   // Fill every line position so later prints never read an unloaded entry
   task automatic test_line_load();
      logic [7:0] val;
      for (int i = 0; i < LINE_CHARS; i++) begin
         if (i == 0)
            val = 8'h00;
         else if (i == LINE_CHARS - 1)
            val = 8'hFF;
         else
            val = 8'($urandom_range(1, 254));
         send_item(CMD_LOAD, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   4'(i), val, 5'($urandom_range(0, 31)));
      end
   endtask

   task automatic test_directed_commands();
      // Nothing running yet: polls must stay silent
      send_item(CMD_POLL, 1'b0, 1'b0, '0, '0, '0);
      send_item(CMD_POLL, 1'b1, 1'b1, '0, '0, '0);
      // Print before init is held pending; an over-long length clamps to a full line
      send_item(CMD_PRINT, 1'b1, 1'b0, '0, '0, 5'd31);
      // Init from reset values, with the bus busy on the next step
      send_item(CMD_INIT, 1'b0, 1'b1, '0, '0, '0);
      send_item(CMD_POLL, 1'b0, 1'b1, '0, '0, '0);
      // Restart init part way through, then restart the pending print
      send_item(CMD_INIT, 1'b1, 1'b0, '0, '0, '0);
      send_item(CMD_PRINT, 1'b1, 1'b1, '0, '0, 5'd16);
      send_item(CMD_LOAD, 1'b1, 1'b1, 4'd3, 8'h41, '0);
   endtask

   task automatic test_register_extremes();
      // Every wait at zero: sequences run flat out
      run_episode(7'd0, 8'd0, 8'd0, 8'd0, 45);
      // Everything at maximum: init parks in the power-up wait
      run_episode(7'd127, 8'd255, 8'd255, 8'd255, 12);
      // Fast power-up, then the long character gap stalls the wake sequence
      run_episode(7'd127, 8'd0, 8'd255, 8'd255, 15);
   endtask

   task automatic test_random_traffic();
      int sent;
      int polls;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         polls = $urandom_range(35, 80);
         run_episode(7'($urandom_range(0, 127)), 8'($urandom_range(0, 6)),
                     8'($urandom_range(0, 4)), 8'($urandom_range(0, 2)), polls);
         sent += polls + 2;
      end
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
   endfunction

   // Response side: stall at random, take each byte and compare it against
   // the oldest prediction
   initial begin : byte_checker
      lcd_byte_type want;
      int           stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(pop_quiet);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected byte %h with nothing predicted", rsp_out_byte);
         end else begin
            want = expected_bytes.pop_front();
            check_field("out_byte", want.out_byte, rsp_out_byte);
            check_field("byte_valid", 8'd1, 8'(rsp_byte_valid));
            check_field("last_byte", 8'(want.last_byte), 8'(rsp_last_byte));
            check_field("dev_address", 8'(want.dev_address), 8'(rsp_dev_address));
            check_field("busy_res", 8'(want.busy), 8'(rsp_busy_res));
            check_field("init_done", 8'(want.init_done), 8'(rsp_init_done));
         end
      end
   end

   initial begin
      for (int i = 0; i < LINE_CHARS; i++)
         line_buf[i] = '0;
      // Hold reset at the start, then release it for good
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_line_load();
      test_directed_commands();
      test_register_extremes();
      test_random_traffic();
      drain();
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
